FILE: rtl/psl_pkg.sv
// Package for the per-source connection limiter: field widths, register codes,
// reset values, the state machine encoding and the structs shared between modules.
// No dependencies.
package psl_pkg;

   localparam int IP_W    = 32;
   localparam int TIME_W  = 48;
   localparam int COUNT_W = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;
   localparam logic [COUNT_W-1:0] COUNT_ONE = 4'h1;
   localparam logic [TIME_W-1:0]  TIME_MAX  = 48'hFFFF_FFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY = 3'd4;

   localparam logic [15:0] WINDOW_RST  = 16'd5000;
   localparam logic [3:0]  LIMIT_RST   = 4'd5;
   localparam logic [15:0] BURST_RST   = 16'd500;
   localparam logic [23:0] BLOCK_RST   = 24'd3000;
   localparam logic [15:0] PENALTY_RST = 16'd250;

   typedef struct packed {
      logic [15:0] window_ms;
      logic [3:0]  attempt_limit;
      logic [15:0] burst_ms;
      logic [23:0] block_ms;
      logic [15:0] penalty_ms;
   } psl_cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  last_time;
      logic [TIME_W-1:0]  blocked_until;
      logic [COUNT_W-1:0] count;
   } psl_rec_type;

   typedef struct packed {
      logic rd_en;
      logic calc_en;
      logic upd_en;
      logic alloc_en;
   } psl_rmw_ctrl_type;

   typedef struct packed {
      logic done;
      logic hit;
   } psl_scan_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_UPDATE,
      ST_FINISH
   } psl_state_type;

endpackage

FILE: rtl/psl_tag_scan.sv
// Source address memory and its sequential lookup, one entry compared per cycle.
// Depends on psl_pkg.
module psl_tag_scan #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [psl_pkg::IP_W-1:0]               ip,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     fill,
   input  logic                                   wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]       wr_idx,
   output psl_pkg::psl_scan_sts_type              sts,
   output logic [$clog2(TABLE_ENTRIES)-1:0]       hit_idx
);
   import psl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [IP_W-1:0]  tag_mem [TABLE_ENTRIES];
   logic [IP_W-1:0]  tag_q_ff;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             busy_ff, busy_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             hit_now, all_issued, done, rd_en;

   assign hit_now    = busy_ff && cmp_vld_ff && (tag_q_ff == ip);
   assign all_issued = (issue_ff == fill);
   assign done       = busy_ff && (hit_now || all_issued);
   assign rd_en      = busy_ff && !hit_now && !all_issued;

   always_comb begin
      busy_in    = busy_ff;
      issue_in   = issue_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      if (start) begin
         busy_in    = 1'b1;
         issue_in   = '0;
         cmp_vld_in = 1'b0;
      end else if (rd_en) begin
         issue_in   = issue_ff + CNT_W'(1);
         cmp_vld_in = 1'b1;
         cmp_idx_in = issue_ff[IDX_W-1:0];
      end else if (done) begin
         busy_in    = 1'b0;
         cmp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cmp_vld_ff <= 1'b0;
         issue_ff   <= '0;
      end else begin
         busy_ff    <= busy_in;
         cmp_vld_ff <= cmp_vld_in;
         issue_ff   <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_idx] <= ip;
      end
      if (rd_en) begin
         tag_q_ff <= tag_mem[issue_ff[IDX_W-1:0]];
      end
   end

   assign sts.done = done;
   assign sts.hit  = hit_now;
   assign hit_idx  = cmp_idx_ff;

endmodule

FILE: rtl/psl_entry_rmw.sv
// Per-address record memory with its read, two-stage update and write-back path.
// Depends on psl_pkg.
module psl_entry_rmw #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                               clock,
   input  psl_pkg::psl_rmw_ctrl_type          ctrl,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]   idx,
   input  logic [psl_pkg::TIME_W-1:0]         now,
   input  psl_pkg::psl_cfg_type               cfg,
   output logic                               accept
);
   import psl_pkg::*;

   psl_rec_type        rec_mem [TABLE_ENTRIES];
   psl_rec_type        rec_q_ff;
   psl_rec_type        wr_rec;
   logic               wr_en;

   logic               blocked_ff;
   logic [TIME_W-1:0]  ext_ff, fresh_ff, gap_ff;
   logic [COUNT_W-1:0] cnt_inc_ff;

   logic [TIME_W:0]    ext_sum, fresh_sum;
   logic               in_window, over_limit, in_burst;
   psl_rec_type        upd_rec;

   assign ext_sum   = {1'b0, rec_q_ff.blocked_until} + {(TIME_W - 15)'(0), cfg.penalty_ms};
   assign fresh_sum = {1'b0, now} + {(TIME_W - 23)'(0), cfg.block_ms};

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rec_q_ff <= rec_mem[idx];
      end
      if (wr_en) begin
         rec_mem[idx] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.calc_en) begin
         blocked_ff <= rec_q_ff.blocked_until > now;
         ext_ff     <= ext_sum[TIME_W] ? TIME_MAX : ext_sum[TIME_W-1:0];
         fresh_ff   <= fresh_sum[TIME_W] ? TIME_MAX : fresh_sum[TIME_W-1:0];
         gap_ff     <= (now >= rec_q_ff.last_time) ? (now - rec_q_ff.last_time) : '0;
         cnt_inc_ff <= (rec_q_ff.count == COUNT_MAX) ? COUNT_MAX
                                                     : (rec_q_ff.count + COUNT_ONE);
      end
   end

   assign in_window  = gap_ff <= {(TIME_W - 16)'(0), cfg.window_ms};
   assign in_burst   = gap_ff <= {(TIME_W - 16)'(0), cfg.burst_ms};
   assign over_limit = cnt_inc_ff > cfg.attempt_limit;

   always_comb begin
      upd_rec = rec_q_ff;
      accept  = 1'b1;
      if (blocked_ff) begin
         upd_rec.blocked_until = ext_ff;
         accept                = 1'b0;
      end else begin
         upd_rec.last_time = now;
         if (in_window) begin
            if (over_limit) begin
               upd_rec.count = '0;
               if (in_burst) begin
                  upd_rec.blocked_until = fresh_ff;
                  accept                = 1'b0;
               end
            end else begin
               upd_rec.count = cnt_inc_ff;
            end
         end else begin
            upd_rec.count = COUNT_ONE;
         end
      end
   end

   always_comb begin
      wr_en  = ctrl.upd_en || ctrl.alloc_en;
      wr_rec = upd_rec;
      if (ctrl.alloc_en) begin
         wr_rec.last_time     = now;
         wr_rec.blocked_until = '0;
         wr_rec.count         = COUNT_ONE;
      end
   end

endmodule

FILE: rtl/per_source_connection_limiter.sv
// Top level of the per-source connection limiter: registers, control sequencer,
// fill count and result register. Depends on psl_pkg, psl_tag_scan and psl_entry_rmw.
//
//   Port group   Direction  Handshake          Payload
//   req_         in         req_valid/ready    client_ip, now_ms
//   rsp_         out        rsp_valid/ready    accept, untracked
//   csr_         in         csr_wr_en          csr_index, csr_wdata
//
// One beat is handled at a time. After the request beat the address memory is read one entry
// per cycle until a match or until all stored addresses (fill) have been compared; on a hit the
// record is then read, recalculated and written back (ST_CALC, ST_UPDATE) before ST_FINISH
// loads the result and raises rsp_valid. The next request beat is taken back in ST_IDLE.
// Reset clears the registers to their defaults and empties the table at once.
// A waiting result never blocks the next request; only a second result stalls.
module per_source_connection_limiter #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [psl_pkg::IP_W-1:0]           req_client_ip,
   input  logic [psl_pkg::TIME_W-1:0]         req_now_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_accept,
   output logic                               rsp_untracked,
   input  logic                               csr_wr_en,
   input  logic [psl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import psl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   psl_state_type     state_ff, state_in;
   psl_cfg_type       cfg_ff;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [IP_W-1:0]   ip_ff;
   logic [TIME_W-1:0] now_ff;
   logic              res_accept_ff, res_accept_in;
   logic              res_untracked_ff, res_untracked_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accept_ff, rsp_untracked_ff;

   logic              req_beat, rsp_load, scan_start, table_full;
   psl_scan_sts_type  scan_sts;
   logic [IDX_W-1:0]  hit_idx, rec_idx;
   psl_rmw_ctrl_type  rmw_ctrl;
   logic              upd_accept;

   assign req_beat   = req_valid && req_ready;
   assign table_full = (fill_ff == CNT_W'(TABLE_ENTRIES));
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_sts.done) begin
               state_in = scan_sts.hit ? ST_CALC : ST_FINISH;
            end
         end
         ST_CALC:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      scan_start       = 1'b0;
      rmw_ctrl         = '0;
      rec_idx          = hit_idx;
      fill_in          = fill_ff;
      res_accept_in    = res_accept_ff;
      res_untracked_in = res_untracked_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_start = req_valid;
         end
         ST_SCAN: begin
            if (scan_sts.done) begin
               if (scan_sts.hit) begin
                  rmw_ctrl.rd_en = 1'b1;
               end else begin
                  res_accept_in    = 1'b1;
                  res_untracked_in = table_full;
                  if (!table_full) begin
                     rmw_ctrl.alloc_en = 1'b1;
                     rec_idx           = fill_ff[IDX_W-1:0];
                     fill_in           = fill_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_CALC: begin
            rmw_ctrl.calc_en = 1'b1;
         end
         ST_UPDATE: begin
            rmw_ctrl.upd_en  = 1'b1;
            res_accept_in    = upd_accept;
            res_untracked_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         fill_ff             <= '0;
         rsp_valid_ff        <= 1'b0;
         cfg_ff.window_ms    <= WINDOW_RST;
         cfg_ff.attempt_limit <= LIMIT_RST;
         cfg_ff.burst_ms     <= BURST_RST;
         cfg_ff.block_ms     <= BLOCK_RST;
         cfg_ff.penalty_ms   <= PENALTY_RST;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WINDOW:  cfg_ff.window_ms     <= csr_wdata[15:0];
               CSR_LIMIT:   cfg_ff.attempt_limit <= csr_wdata[3:0];
               CSR_BURST:   cfg_ff.burst_ms      <= csr_wdata[15:0];
               CSR_BLOCK:   cfg_ff.block_ms      <= csr_wdata[23:0];
               CSR_PENALTY: cfg_ff.penalty_ms    <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         ip_ff  <= req_client_ip;
         now_ff <= req_now_ms;
      end
      res_accept_ff    <= res_accept_in;
      res_untracked_ff <= res_untracked_in;
      if (rsp_load) begin
         rsp_accept_ff    <= res_accept_ff;
         rsp_untracked_ff <= res_untracked_ff;
      end
   end

   psl_tag_scan #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_tag_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .ip      (ip_ff),
      .fill    (fill_ff),
      .wr_en   (rmw_ctrl.alloc_en),
      .wr_idx  (rec_idx),
      .sts     (scan_sts),
      .hit_idx (hit_idx)
   );

   psl_entry_rmw #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_entry_rmw (
      .clock  (clock),
      .ctrl   (rmw_ctrl),
      .idx    (rec_idx),
      .now    (now_ff),
      .cfg    (cfg_ff),
      .accept (upd_accept)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accept    = rsp_accept_ff;
   assign rsp_untracked = rsp_untracked_ff;

   a_beat_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a lookup");

   a_alloc_grows_fill: assert property (@(posedge clock) disable iff (reset)
      rmw_ctrl.alloc_en |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("allocation did not advance the fill count");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finishing step");

   a_untracked_accepts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_untracked) |-> (rsp_accept && $past(table_full)))
      else $error("untracked result without a full table or refused");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for per_source_connection_limiter: a queue-fed driver, a ready
// generator and a monitor that checks each result beat against a predicted verdict.
// Depends on psl_pkg and the per_source_connection_limiter RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psl_pkg::*;

   localparam int SLOTS = 16;

   typedef struct packed {
      logic [IP_W-1:0]   ip;
      logic [TIME_W-1:0] now;
   } attempt_type;

   typedef struct packed {
      logic accept;
      logic untracked;
   } verdict_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [IP_W-1:0]       req_client_ip = '0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_accept;
   logic                  rsp_untracked;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   psl_cfg_type           rate_cfg;
   logic                  slot_used [SLOTS];
   logic [IP_W-1:0]       slot_ip [SLOTS];
   logic [TIME_W-1:0]     slot_last [SLOTS];
   logic [TIME_W-1:0]     slot_until [SLOTS];
   logic [COUNT_W-1:0]    slot_count [SLOTS];

   attempt_type           attempt_queue [$];
   verdict_type           expected_verdicts [$];
   logic [IP_W-1:0]       seen_ips [$];
   logic [TIME_W-1:0]     ip_clock [$];
   int                    last_pick = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   logic                  hold_off_wanted = 1'b0;
   logic                  hold_off_done = 1'b0;
   int                    hold_left = 0;
   logic                  failed = 1'b0;

   per_source_connection_limiter #(
      .TABLE_ENTRIES(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_client_ip(req_client_ip),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_accept(rsp_accept),
      .rsp_untracked(rsp_untracked),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [TIME_W-1:0] time_plus(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

   function automatic verdict_type judge_attempt(input logic [IP_W-1:0] ip,
                                                 input logic [TIME_W-1:0] now);
      verdict_type v;
      int hit;
      int spare;
      logic [TIME_W-1:0] gap;
      hit = -1;
      spare = -1;
      v.accept = 1'b1;
      v.untracked = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[i]) begin
            if (hit < 0 && slot_ip[i] == ip) hit = i;
         end else if (spare < 0) begin
            spare = i;
         end
      end
      if (hit < 0) begin
         if (spare < 0) begin
            v.untracked = 1'b1;
         end else begin
            slot_used[spare] = 1'b1;
            slot_ip[spare] = ip;
            slot_last[spare] = now;
            slot_until[spare] = '0;
            slot_count[spare] = COUNT_ONE;
         end
         return v;
      end
      if (slot_until[hit] > now) begin
         slot_until[hit] = time_plus(slot_until[hit], TIME_W'(rate_cfg.penalty_ms));
         v.accept = 1'b0;
         return v;
      end
      gap = (now >= slot_last[hit]) ? now - slot_last[hit] : '0;
      slot_last[hit] = now;
      if (gap <= TIME_W'(rate_cfg.window_ms)) begin
         if (slot_count[hit] != COUNT_MAX) slot_count[hit] = slot_count[hit] + 1'b1;
         if (slot_count[hit] > rate_cfg.attempt_limit) begin
            slot_count[hit] = '0;
            if (gap <= TIME_W'(rate_cfg.burst_ms)) begin
               slot_until[hit] = time_plus(now, TIME_W'(rate_cfg.block_ms));
               v.accept = 1'b0;
            end
         end
      end else begin
         slot_count[hit] = COUNT_ONE;
      end
      return v;
   endfunction

   always @(posedge clock) begin : drive_attempts
      attempt_type a;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_verdicts.push_back(judge_attempt(req_client_ip, req_now_ms));
         end
         if (!req_valid || req_ready) begin
            if (attempt_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               a = attempt_queue.pop_front();
               req_valid <= 1'b1;
               req_client_ip <= a.ip;
               req_now_ms <= a.now;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_off_wanted && !hold_off_done) begin
         hold_left <= 400;
         hold_off_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: result beat with nothing expected: accept %0b untracked %0b",
                     $time, rsp_accept, rsp_untracked);
            failed = 1'b1;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_accept !== want.accept) begin
               $display("%0t: accept expected %0b actual %0b",
                        $time, want.accept, rsp_accept);
               failed = 1'b1;
            end
            if (rsp_untracked !== want.untracked) begin
               $display("%0t: untracked expected %0b actual %0b",
                        $time, want.untracked, rsp_untracked);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_WINDOW:  rate_cfg.window_ms = val[15:0];
         CSR_LIMIT:   rate_cfg.attempt_limit = val[3:0];
         CSR_BURST:   rate_cfg.burst_ms = val[15:0];
         CSR_BLOCK:   rate_cfg.block_ms = val[23:0];
         CSR_PENALTY: rate_cfg.penalty_ms = val[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_attempt(input logic [IP_W-1:0] ip, input logic [TIME_W-1:0] now);
      attempt_type a;
      int k;
      k = -1;
      foreach (seen_ips[i]) begin
         if (k < 0 && seen_ips[i] == ip) k = i;
      end
      if (k < 0) begin
         seen_ips.push_back(ip);
         ip_clock.push_back(now);
         k = seen_ips.size() - 1;
      end else begin
         ip_clock[k] = now;
      end
      last_pick = k;
      a.ip = ip;
      a.now = now;
      attempt_queue.push_back(a);
   endtask

   // Most beats revisit stored sources, often the same one again, so that counts build
   // up and blocks are reached; a few bring new sources, which overflow the table later.
   task automatic queue_random_attempts(input int count);
      int pick;
      int roll;
      int span;
      logic [IP_W-1:0] ip;
      logic [63:0] t;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         span = (seen_ips.size() < 20) ? seen_ips.size() : 20;
         if (span == 0 || roll < 8) begin
            ip = $urandom();
            if ($urandom_range(0, 9) == 0) t = 64'(TIME_MAX) - $urandom_range(0, 100000);
            else t = {$urandom_range(0, 65535), $urandom()};
         end else begin
            pick = (roll < 45) ? last_pick : $urandom_range(0, span - 1);
            ip = seen_ips[pick];
            t = 64'(ip_clock[pick]);
            roll = $urandom_range(0, 99);
            if (roll < 40) t += $urandom_range(0, rate_cfg.burst_ms);
            else if (roll < 65) t += $urandom_range(rate_cfg.burst_ms, rate_cfg.window_ms);
            else if (roll < 80) t += 64'(rate_cfg.window_ms) + 1 + $urandom_range(0, 2000);
            else if (roll < 90) t += $urandom_range(0, rate_cfg.block_ms + 5000);
            else if (roll < 95) t = (t > 5000) ? t - $urandom_range(1, 5000) : 64'd0;
            else t += $urandom();
            if (t > 64'(TIME_MAX)) t = 64'(TIME_MAX);
         end
         queue_attempt(ip, t[TIME_W-1:0]);
      end
   endtask

   task automatic drain;
      do @(negedge clock);
      while (attempt_queue.size() != 0 || req_valid || expected_verdicts.size() != 0);
   endtask

   task automatic run_phase(input int window, input int limit, input int burst,
                            input int block, input int penalty, input int send_pct,
                            input int recv_pct, input int count, input logic hold);
      write_reg(CSR_WINDOW, CSR_DATA_W'(window));
      write_reg(CSR_LIMIT, CSR_DATA_W'(limit));
      write_reg(CSR_BURST, CSR_DATA_W'(burst));
      write_reg(CSR_BLOCK, CSR_DATA_W'(block));
      write_reg(CSR_PENALTY, CSR_DATA_W'(penalty));
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      queue_random_attempts(count);
      hold_off_wanted = hold;
      drain();
   endtask

   initial begin : run_phases
      int w;
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      rate_cfg.window_ms = WINDOW_RST;
      rate_cfg.attempt_limit = LIMIT_RST;
      rate_cfg.burst_ms = BURST_RST;
      rate_cfg.block_ms = BLOCK_RST;
      rate_cfg.penalty_ms = PENALTY_RST;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 22;
      recv_idle_pct = 65;

      // Under the reset settings: a burst that blocks, a refused attempt that extends the
      // block, release exactly at the block time, time going backwards, a gap past the
      // window, passing the limit slowly, and a block that saturates at the top of time.
      for (int i = 0; i <= 5; i++) queue_attempt(32'h0000_0000, TIME_W'(i * 100));
      queue_attempt(32'h0000_0000, 48'd600);
      queue_attempt(32'h0000_0000, 48'd3750);
      queue_attempt(32'h0000_0000, 48'd100);
      for (int i = 0; i <= 5; i++) queue_attempt(32'h0000_0000, TIME_W'(20000 + i * 1000));
      for (int i = 0; i <= 5; i++) queue_attempt(32'hFFFF_FFFF, TIME_MAX - 48'd1000);
      queue_attempt(32'hFFFF_FFFF, TIME_MAX - 48'd1);
      queue_attempt(32'hFFFF_FFFF, TIME_MAX);
      queue_random_attempts(110);
      drain();

      run_phase(2000, 3, 800, 5000, 1000, 22, 65, 145, 1'b0);
      run_phase(0, 0, 0, 0, 0, 65, 22, 145, 1'b0);
      run_phase(65535, 15, 65535, 16777215, 65535, 65, 22, 145, 1'b0);
      w = $urandom_range(200, 10000);
      run_phase(w, $urandom_range(1, 14), $urandom_range(0, w), $urandom_range(0, 20000),
                $urandom_range(0, 2000), 0, 0, 145, 1'b1);
      run_phase(65535, 14, 0, 1, 65535, 0, 0, 145, 1'b0);

      repeat (SLOTS + 8) @(posedge clock);
      if (!failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/psl_pkg.sv
rtl/psl_tag_scan.sv
rtl/psl_entry_rmw.sv
rtl/per_source_connection_limiter.sv
dv/tb.sv
